/* design/sample_statistics_accumulator_core_defines.svh */
// Assertion macros for the sample statistics accumulator.
// Taken in by the top level only; no other dependencies.
`ifndef SAMPLE_STATISTICS_ACCUMULATOR_CORE_DEFINES_SVH
`define SAMPLE_STATISTICS_ACCUMULATOR_CORE_DEFINES_SVH

// same-cycle implication
`define SSA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/ssa_pkg.sv */
// Shared widths, constants and controller/datapath interface structs
// for the sample statistics accumulator. No dependencies.
`default_nettype none
package ssa_pkg;
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 11;
    localparam int SUM_W      = 26;
    localparam int SQ_W       = 41;
    localparam int MEAN_W     = 24;
    localparam int VAR_W      = 38;
    localparam int DEV_W      = 23;
    localparam int FRAC       = 8;
    localparam int PROD_W     = 52;
    localparam int DIVD_W     = 60;
    localparam int DIVS_W     = 21;
    localparam int ROOT_IN_W  = 46;
    localparam int OUT_DATA_W = 176;
    localparam logic [COUNT_W-1:0] CAPACITY = 11'd1024;

    typedef struct packed {
        logic acc_en;
        logic cap_en;
        logic mul_en;
        logic div_start;
        logic div_var;
        logic mean_ld;
        logic var_ld;
        logic dev_ld;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
    } t_stat;
endpackage
`default_nettype wire

/* design/sample_statistics_accumulator_core.sv */
// Streaming sample statistics: one signed 16-bit sample per request, tlast closes
// the set. A sample is taken every cycle while a set accumulates; after the last
// sample the block forms the products, divides for the mean, divides for the
// variance on the same divider and takes the root, then loads the result
// register once the previous result has been taken. Capacity is 1024 samples
// per set; further samples are dropped and flagged in tuser. Mean, variance and
// deviation are Q8. Depends on ssa_pkg, ssa_ctrl, ssa_datapath and the defines
// header.
`default_nettype none
`include "sample_statistics_accumulator_core_defines.svh"
module sample_statistics_accumulator_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [15:0]  i_s_axis_tdata,  // sample[15:0]
    input  wire logic         i_s_axis_tlast,  // last_sample
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // sample_count[10:0] total[36:11] smallest[52:37] largest[68:53]
    // spread[84:69] mean_q8[108:85] variance_q8[146:109] deviation_q8[169:147]
    output logic [175:0]      o_m_axis_tdata,
    output logic              o_m_axis_tuser   // overflow
);
    ssa_pkg::t_cmd  cmd;
    ssa_pkg::t_stat stat;

    ssa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tlast  (i_s_axis_tlast),
        .i_m_tready (i_m_axis_tready),
        .i_stat     (stat),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_cmd      (cmd)
    );

    ssa_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_sample (i_s_axis_tdata),
        .o_stat   (stat),
        .o_data   (o_m_axis_tdata),
        .o_drop   (o_m_axis_tuser)
    );

    `SSA_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, !o_s_axis_tready, "input taken during set computation")
    `SSA_ASSERT_NOW(a_root_floor, i_clk, i_rst_n, o_m_axis_tvalid, (46'(o_m_axis_tdata[169:147]) * 46'(o_m_axis_tdata[169:147])) <= {o_m_axis_tdata[146:109], 8'b0}, "deviation above root of variance")
    `SSA_ASSERT_NOW(a_root_tight, i_clk, i_rst_n, o_m_axis_tvalid, (48'(o_m_axis_tdata[169:147]) + 48'd1) * (48'(o_m_axis_tdata[169:147]) + 48'd1) > 48'({o_m_axis_tdata[146:109], 8'b0}), "deviation below root of variance")
endmodule
`default_nettype wire

/* design/ssa_div.sv */
// Restoring divider, one quotient bit per cycle.
// Uses ssa_pkg widths.
`default_nettype none
module ssa_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ssa_pkg::DIVD_W-1:0]  i_dividend,
    input  wire logic [ssa_pkg::DIVS_W-1:0]  i_divisor,
    output logic      [ssa_pkg::DIVD_W-1:0]  o_quotient,
    output logic                             o_done
);
    localparam int STEPS = ssa_pkg::DIVD_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [ssa_pkg::DIVS_W-1:0] r_rem, n_rem;
    logic [ssa_pkg::DIVD_W-1:0] r_quo, n_quo;
    logic [ssa_pkg::DIVS_W-1:0] r_dvs;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy, r_done;
    logic [ssa_pkg::DIVS_W:0]   trial;

    always_comb begin
        trial = {r_rem, r_quo[ssa_pkg::DIVD_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = ssa_pkg::DIVS_W'(trial - {1'b0, r_dvs});
            n_quo = {r_quo[ssa_pkg::DIVD_W-2:0], 1'b1};
        end else begin
            n_rem = trial[ssa_pkg::DIVS_W-1:0];
            n_quo = {r_quo[ssa_pkg::DIVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;
endmodule
`default_nettype wire

/* design/ssa_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
// Uses ssa_pkg widths.
`default_nettype none
module ssa_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ssa_pkg::ROOT_IN_W-1:0] i_radicand,
    output logic      [ssa_pkg::DEV_W-1:0]     o_root,
    output logic                               o_done
);
    localparam int STEPS = ssa_pkg::DEV_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int REM_W = ssa_pkg::DEV_W + 2;

    logic [ssa_pkg::ROOT_IN_W-1:0] r_x;
    logic [REM_W-1:0]              r_rem, n_rem;
    logic [ssa_pkg::DEV_W-1:0]     r_root, n_root;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_busy, r_done;
    logic [REM_W+1:0]              t;
    logic [REM_W+1:0]              trial;

    always_comb begin
        t     = {r_rem, r_x[ssa_pkg::ROOT_IN_W-1 -: 2]};
        trial = (REM_W+2)'({r_root, 2'b01});
        if (t >= trial) begin
            n_rem  = REM_W'(t - trial);
            n_root = {r_root[ssa_pkg::DEV_W-2:0], 1'b1};
        end else begin
            n_rem  = t[REM_W-1:0];
            n_root = {r_root[ssa_pkg::DEV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[ssa_pkg::ROOT_IN_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;
endmodule
`default_nettype wire

/* design/ssa_datapath.sv */
// Accumulators, set capture, products, divider and root units, result register.
// Uses ssa_pkg, ssa_div and ssa_sqrt.
`default_nettype none
module ssa_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ssa_pkg::t_cmd                   i_cmd,
    input  wire logic [ssa_pkg::SAMPLE_W-1:0]    i_sample,
    output ssa_pkg::t_stat                       o_stat,
    output logic      [ssa_pkg::OUT_DATA_W-1:0]  o_data,
    output logic                                 o_drop
);
    logic        [ssa_pkg::COUNT_W-1:0] r_count, u_count;
    logic signed [ssa_pkg::SUM_W-1:0]   r_sum, u_sum;
    logic        [ssa_pkg::SQ_W-1:0]    r_sq, u_sq;
    logic signed [ssa_pkg::SAMPLE_W-1:0] r_min, r_max, u_min, u_max, s;
    logic                               r_drop, u_drop, room;
    logic signed [2*ssa_pkg::SAMPLE_W-1:0] sq_s;

    logic        [ssa_pkg::COUNT_W-1:0] r_cn;
    logic signed [ssa_pkg::SUM_W-1:0]   r_csum;
    logic        [ssa_pkg::SUM_W-1:0]   r_cmag, u_mag;
    logic        [ssa_pkg::SQ_W-1:0]    r_csq;
    logic signed [ssa_pkg::SAMPLE_W-1:0] r_cmin, r_cmax;
    logic                               r_cdrop;

    logic [ssa_pkg::PROD_W-1:0] r_nsq, r_magsq, dnum;
    logic [ssa_pkg::DIVS_W-1:0] r_nn;
    logic [ssa_pkg::DIVD_W-1:0] div_dividend, quo;
    logic [ssa_pkg::DIVS_W-1:0] div_divisor;
    logic [ssa_pkg::DEV_W-1:0]  root;
    logic                       div_done, sqrt_done;

    logic [ssa_pkg::MEAN_W-1:0] r_mean;
    logic [ssa_pkg::VAR_W-1:0]  r_var;
    logic [ssa_pkg::DEV_W-1:0]  r_dev;
    logic [ssa_pkg::OUT_DATA_W-1:0] r_data;
    logic                       r_odrop;

    always_comb begin
        s       = $signed(i_sample);
        room    = r_count < ssa_pkg::CAPACITY;
        sq_s    = s * s;
        u_count = r_count;
        u_sum   = r_sum;
        u_sq    = r_sq;
        u_min   = r_min;
        u_max   = r_max;
        u_drop  = r_drop;
        if (room) begin
            u_count = r_count + 1'b1;
            u_sum   = r_sum + ssa_pkg::SUM_W'(s);
            u_sq    = r_sq + ssa_pkg::SQ_W'($unsigned(sq_s));
            if (s < r_min) u_min = s;
            if (s > r_max) u_max = s;
        end else begin
            u_drop = 1'b1;
        end
        u_mag = (u_sum < 0) ? ssa_pkg::SUM_W'(-u_sum) : ssa_pkg::SUM_W'(u_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_min   <= {1'b0, {(ssa_pkg::SAMPLE_W-1){1'b1}}};
            r_max   <= {1'b1, {(ssa_pkg::SAMPLE_W-1){1'b0}}};
            r_drop  <= 1'b0;
        end else if (i_cmd.acc_en) begin
            if (i_cmd.cap_en) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sq    <= '0;
                r_min   <= {1'b0, {(ssa_pkg::SAMPLE_W-1){1'b1}}};
                r_max   <= {1'b1, {(ssa_pkg::SAMPLE_W-1){1'b0}}};
                r_drop  <= 1'b0;
            end else begin
                r_count <= u_count;
                r_sum   <= u_sum;
                r_sq    <= u_sq;
                r_min   <= u_min;
                r_max   <= u_max;
                r_drop  <= u_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            r_cn    <= u_count;
            r_csum  <= u_sum;
            r_cmag  <= u_mag;
            r_csq   <= u_sq;
            r_cmin  <= u_min;
            r_cmax  <= u_max;
            r_cdrop <= u_drop;
        end
        if (i_cmd.mul_en) begin
            r_nsq   <= ssa_pkg::PROD_W'(r_cn * r_csq);
            r_magsq <= ssa_pkg::PROD_W'(r_cmag * r_cmag);
            r_nn    <= ssa_pkg::DIVS_W'(r_cn * r_cn);
        end
        if (i_cmd.mean_ld)
            r_mean <= (r_csum < 0) ? ssa_pkg::MEAN_W'(-quo[ssa_pkg::MEAN_W-1:0])
                                   : quo[ssa_pkg::MEAN_W-1:0];
        if (i_cmd.var_ld)
            r_var <= quo[ssa_pkg::VAR_W-1:0];
        if (i_cmd.dev_ld)
            r_dev <= root;
        if (i_cmd.out_ld) begin
            r_data  <= {6'b0, r_dev, r_var, r_mean,
                        ssa_pkg::SAMPLE_W'(r_cmax - r_cmin),
                        r_cmax, r_cmin, r_csum, r_cn};
            r_odrop <= r_cdrop;
        end
    end

    always_comb begin
        dnum = (r_nsq >= r_magsq) ? r_nsq - r_magsq : '0;
        if (i_cmd.div_var) begin
            div_dividend = {dnum, {ssa_pkg::FRAC{1'b0}}};
            div_divisor  = r_nn;
        end else begin
            div_dividend = ssa_pkg::DIVD_W'({r_cmag, {ssa_pkg::FRAC{1'b0}}});
            div_divisor  = ssa_pkg::DIVS_W'(r_cn);
        end
    end

    ssa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    ssa_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.var_ld),
        .i_radicand ({quo[ssa_pkg::VAR_W-1:0], {ssa_pkg::FRAC{1'b0}}}),
        .o_root     (root),
        .o_done     (sqrt_done)
    );

    assign o_stat.div_done  = div_done;
    assign o_stat.sqrt_done = sqrt_done;
    assign o_data = r_data;
    assign o_drop = r_odrop;
endmodule
`default_nettype wire

/* design/ssa_ctrl.sv */
// Sequencer: accumulate, products, mean divide, variance divide, root, result.
// Uses ssa_pkg command/status structs.
`default_nettype none
module ssa_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    input  wire logic           i_s_tlast,
    input  wire logic           i_m_tready,
    input  wire ssa_pkg::t_stat i_stat,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    output ssa_pkg::t_cmd       o_cmd
);
    typedef enum logic [5:0] {
        ST_ACC  = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_DIVM = 6'b000100,
        ST_DIVV = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   acc;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        acc     = (r_state == ST_ACC) && i_s_tvalid;
        o_cmd.acc_en = acc;
        case (r_state)
            ST_ACC: begin
                if (acc && i_s_tlast) begin
                    o_cmd.cap_en = 1'b1;
                    n_state      = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIVM;
            end
            ST_DIVM: begin
                if (i_stat.div_done) begin
                    o_cmd.mean_ld   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_var   = 1'b1;
                    n_state         = ST_DIVV;
                end
            end
            ST_DIVV: begin
                o_cmd.div_var = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.var_ld = 1'b1;
                    n_state      = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.dev_ld = 1'b1;
                    n_state      = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = ST_ACC;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACC;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_ld)
                r_out_valid <= 1'b1;
            else if (i_m_tready)
                r_out_valid <= 1'b0;
        end
    end

    assign o_s_tready = (r_state == ST_ACC);
    assign o_m_tvalid = r_out_valid;
endmodule
`default_nettype wire
